// ----- rtl/core/wrh_pkg.sv -----
package wrh_pkg;

    localparam int SECTORS       = 16;
    localparam int SPEED_CLASSES = 6;
    localparam int COUNT_WIDTH   = 20;

    localparam int NBINS  = SECTORS * SPEED_CLASSES;
    localparam int ADDR_W = $clog2(NBINS);

    // field widths of the sample and result channels and of the speed step
    localparam int OP_W     = 2;
    localparam int SPEED_W  = 12;
    localparam int DIR_W    = 12;
    localparam int SECTOR_W = 4;
    localparam int CLASS_W  = 3;
    localparam int STEP_W   = 10;

    // wide enough for class index times speed step
    localparam int PROD_W = 16;

    localparam logic [DIR_W-1:0]       FULL_CIRCLE = DIR_W'(3600);
    localparam logic [STEP_W-1:0]      STEP_RESET  = STEP_W'(80);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // request from the pipeline to the bin store
    typedef struct packed {
        logic                   advance;
        logic [ADDR_W-1:0]      rd_addr;
        logic [ADDR_W-1:0]      cur_addr;
        logic                   wr_en;
        logic [COUNT_WIDTH-1:0] wr_data;
        logic                   clear;
    } wrh_store_req_t;

    // lowest direction that falls in sector k
    function automatic logic [DIR_W-1:0] sector_edge(int k);
        return DIR_W'((k * 3600 + SECTORS - 1) / SECTORS);
    endfunction

endpackage

// ----- rtl/core/wrh_channels.sv -----
interface wrh_sample_if
    import wrh_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [SPEED_W-1:0]  speed;
    logic [DIR_W-1:0]    direction;
    logic                missing;
    logic [SECTOR_W-1:0] read_sector;
    logic [CLASS_W-1:0]  read_class;

    modport source (
        output valid, operation, speed, direction, missing, read_sector, read_class,
        input  ready
    );
    modport sink (
        input  valid, operation, speed, direction, missing, read_sector, read_class,
        output ready
    );
endinterface

interface wrh_result_if
    import wrh_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] count;
    logic                   counted;
    logic [SECTOR_W-1:0]    sector;
    logic [CLASS_W-1:0]     speed_class;

    modport source (
        output valid, count, counted, sector, speed_class,
        input  ready
    );
    modport sink (
        input  valid, count, counted, sector, speed_class,
        output ready
    );
endinterface

// ----- rtl/core/wrh_bin_store.sv -----
module wrh_bin_store
    import wrh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  wrh_store_req_t         req,
    output logic [COUNT_WIDTH-1:0] old_count
);

    logic [COUNT_WIDTH-1:0] mem [NBINS];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [NBINS-1:0]       bin_valid_reg;
    logic                   fwd_valid_reg;
    logic [ADDR_W-1:0]      fwd_addr_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.advance)
        begin
            rd_data_reg <= mem[req.rd_addr];
            if (req.wr_en)
            begin
                mem[req.cur_addr] <= req.wr_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (req.advance)
        begin
            fwd_valid_reg <= req.wr_en;
            if (req.clear)
            begin
                bin_valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                bin_valid_reg[req.cur_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.advance)
        begin
            fwd_addr_reg <= req.cur_addr;
            fwd_data_reg <= req.wr_data;
        end
    end

    // read data misses the write made at the same edge, so forward it
    always_comb
    begin
        if (!bin_valid_reg[req.cur_addr])
        begin
            old_count = '0;
        end
        else if (fwd_valid_reg && (fwd_addr_reg == req.cur_addr))
        begin
            old_count = fwd_data_reg;
        end
        else
        begin
            old_count = rd_data_reg;
        end
    end

endmodule

// ----- rtl/core/wind_rose_histogram.sv -----
// Wind rose histogram: 16 direction sectors by 6 speed classes of 20-bit
// saturating counters. Each sample transfer carries an operation: add a
// sample, read one bin, or clear all bins; each gives exactly one result
// transfer, in order. One transfer is taken every cycle as long as results
// are taken; each passes through the input register, the memory read stage
// and the result register before its result is offered. The counters live
// in a 96 x 20 memory with one read and one write port; a read-modify-write
// per cycle keeps full rate by forwarding the last write. Per-bin valid
// flops are cleared at once by reset and by a clear operation, so there is
// no clearing pass and the block is ready right after reset. speed_step is
// written through cfg_we / cfg_wdata; the user must write it only while the
// block is idle, which the block does not enforce itself; zero acts as one.
module wind_rose_histogram
    import wrh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [STEP_W-1:0] cfg_wdata,
    wrh_sample_if.sink        samples,
    wrh_result_if.source      results
);

    // whole pipeline moves together whenever the result register can drain
    logic advance;

    logic [STEP_W-1:0] speed_step_reg;

    // stage 1: registered sample
    logic                s1_valid_reg;
    logic [OP_W-1:0]     s1_op_reg;
    logic [SPEED_W-1:0]  s1_speed_reg;
    logic [DIR_W-1:0]    s1_dir_reg;
    logic                s1_missing_reg;
    logic [SECTOR_W-1:0] s1_rsec_reg;
    logic [CLASS_W-1:0]  s1_rcls_reg;

    // stage 1 decode
    logic [STEP_W-1:0]        step_eff;
    logic [DIR_W-1:0]         dir_wrap;
    logic [SECTORS-2:0]       sector_ge;
    logic [SPEED_CLASSES-2:0] class_gt;
    logic [SECTOR_W-1:0]      add_sector;
    logic [CLASS_W-1:0]       add_class;
    logic [ADDR_W-1:0]        add_addr;
    logic [ADDR_W-1:0]        read_addr;
    logic                     sample_ok;
    logic                     s2_write_next;
    logic                     s2_use_next;
    logic                     s2_clear_next;
    logic [ADDR_W-1:0]        s2_addr_next;
    logic [SECTOR_W-1:0]      s2_sector_next;
    logic [CLASS_W-1:0]       s2_class_next;

    // stage 2: memory data available
    logic                s2_valid_reg;
    logic                s2_write_reg;
    logic                s2_use_reg;
    logic                s2_clear_reg;
    logic [ADDR_W-1:0]   s2_addr_reg;
    logic [SECTOR_W-1:0] s2_sector_reg;
    logic [CLASS_W-1:0]  s2_class_reg;

    logic [COUNT_WIDTH-1:0] old_count;
    logic [COUNT_WIDTH-1:0] new_count;
    logic [COUNT_WIDTH-1:0] count_next;
    wrh_store_req_t         store_req;

    // result register
    logic                   out_valid_reg;
    logic [COUNT_WIDTH-1:0] out_count_reg;
    logic                   out_counted_reg;
    logic [SECTOR_W-1:0]    out_sector_reg;
    logic [CLASS_W-1:0]     out_class_reg;

    assign advance       = !out_valid_reg || results.ready;
    assign samples.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            speed_step_reg <= cfg_wdata;
        end
    end

    // valid flags of all stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= samples.valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg      <= samples.operation;
            s1_speed_reg   <= samples.speed;
            s1_dir_reg     <= samples.direction;
            s1_missing_reg <= samples.missing;
            s1_rsec_reg    <= samples.read_sector;
            s1_rcls_reg    <= samples.read_class;
        end
    end

    // sector and class by parallel threshold compares, then a popcount
    always_comb
    begin
        step_eff = (speed_step_reg == '0) ? STEP_W'(1) : speed_step_reg;
        dir_wrap = (s1_dir_reg == FULL_CIRCLE) ? '0 : s1_dir_reg;
        for (int k = 1; k < SECTORS; k++)
        begin
            sector_ge[k-1] = dir_wrap >= sector_edge(k);
        end
        // class k is reached once speed exceeds k steps
        for (int k = 1; k < SPEED_CLASSES; k++)
        begin
            class_gt[k-1] = PROD_W'(s1_speed_reg) > (PROD_W'(k) * PROD_W'(step_eff));
        end
        add_sector = SECTOR_W'($countones(sector_ge));
        add_class  = CLASS_W'($countones(class_gt));
        add_addr   = ADDR_W'(add_sector) * ADDR_W'(SPEED_CLASSES) + ADDR_W'(add_class);
        read_addr  = ADDR_W'(s1_rsec_reg) * ADDR_W'(SPEED_CLASSES) + ADDR_W'(s1_rcls_reg);
        sample_ok  = !s1_missing_reg && (s1_speed_reg != '0) && (s1_dir_reg <= FULL_CIRCLE);
    end

    always_comb
    begin
        s2_write_next  = 1'b0;
        s2_use_next    = 1'b0;
        s2_clear_next  = 1'b0;
        s2_addr_next   = add_addr;
        s2_sector_next = '0;
        s2_class_next  = '0;
        unique case (s1_op_reg)
            OP_ADD:
            begin
                if (sample_ok)
                begin
                    s2_write_next  = 1'b1;
                    s2_sector_next = add_sector;
                    s2_class_next  = add_class;
                end
            end
            OP_READ:
            begin
                // out-of-range reads echo the address with a zero count
                s2_use_next    = (32'(s1_rsec_reg) < SECTORS) &&
                                 (32'(s1_rcls_reg) < SPEED_CLASSES);
                s2_addr_next   = read_addr;
                s2_sector_next = s1_rsec_reg;
                s2_class_next  = s1_rcls_reg;
            end
            OP_CLEAR:
            begin
                s2_clear_next = 1'b1;
            end
            default:
            begin
                s2_write_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_write_reg  <= s2_write_next;
            s2_use_reg    <= s2_use_next;
            s2_clear_reg  <= s2_clear_next;
            s2_addr_reg   <= s2_addr_next;
            s2_sector_reg <= s2_sector_next;
            s2_class_reg  <= s2_class_next;
        end
    end

    // saturating increment on the current bin value
    always_comb
    begin
        new_count = (old_count == COUNT_MAX) ? old_count : old_count + 1'b1;
        if (s2_write_reg)
        begin
            count_next = new_count;
        end
        else if (s2_use_reg)
        begin
            count_next = old_count;
        end
        else
        begin
            count_next = '0;
        end
    end

    always_comb
    begin
        store_req.advance  = advance;
        store_req.rd_addr  = s2_addr_next;
        store_req.cur_addr = s2_addr_reg;
        store_req.wr_en    = s2_valid_reg && s2_write_reg;
        store_req.wr_data  = new_count;
        store_req.clear    = s2_valid_reg && s2_clear_reg;
    end

    wrh_bin_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (store_req),
        .old_count (old_count)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_count_reg   <= count_next;
            out_counted_reg <= s2_write_reg;
            out_sector_reg  <= s2_sector_reg;
            out_class_reg   <= s2_class_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.count       = out_count_reg;
    assign results.counted     = out_counted_reg;
    assign results.sector      = out_sector_reg;
    assign results.speed_class = out_class_reg;

endmodule

// ----- tb/sv/wind_rose_histogram_tb.sv -----
`timescale 1ns / 100ps

module wind_rose_histogram_tb
    import wrh_pkg::*;
();

    // operation code that the block must answer with an all-zero result
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int unsigned IDLE_PCT     = 12;      // idle cycles per hundred, each side
    localparam int unsigned HOLD_CYCLES  = 250;     // long receiver hold-off
    localparam int unsigned DRAIN_CYCLES = 8;       // three-stage pipe plus margin
    localparam int unsigned CYCLE_LIMIT  = 200000;  // far above the slowest correct run
    localparam int unsigned PHASE_ITEMS  = 90;      // random transfers per phase

    // one sample transfer as the sender sees it
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SPEED_W-1:0]  speed;
        logic [DIR_W-1:0]    direction;
        logic                missing;
        logic [SECTOR_W-1:0] read_sector;
        logic [CLASS_W-1:0]  read_class;
    } wind_sample_t;

    // one result transfer
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic                   counted;
        logic [SECTOR_W-1:0]    sector;
        logic [CLASS_W-1:0]     speed_class;
    } bin_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [STEP_W-1:0] cfg_wdata;

    wrh_sample_if samples_ch ();
    wrh_result_if results_ch ();

    wind_rose_histogram dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .samples   (samples_ch),
        .results   (results_ch)
    );

    // samples waiting to be offered, and results the histogram owes us
    wind_sample_t pending_samples[$];
    bin_result_t  awaited_results[$];

    // our own copy of the bin store and the speed step register
    logic [COUNT_WIDTH-1:0] rose_bins [NBINS];
    logic [STEP_W-1:0]      step_width;

    int unsigned  queued_total;
    int unsigned  accepted_total;
    int unsigned  mismatch_count;
    int unsigned  cycle_count;
    int unsigned  hold_requests;
    int unsigned  hold_served;
    int unsigned  hold_left;
    bit           no_idle;
    bit           in_fire;
    wind_sample_t next_sample;

    // free-running clock, 4 ns period
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor: applies one accepted sample transfer to the local bin
    // store and returns the result the histogram should give for it
    // ------------------------------------------------------------------
    function automatic bin_result_t tally_sample(wind_sample_t s);
        bin_result_t       r;
        int unsigned       eff_step;
        int unsigned       dir;
        int unsigned       sec;
        int unsigned       cls;
        logic [ADDR_W-1:0] idx;
        r = '0;
        // a zero step acts as a step of one
        eff_step = (step_width == '0) ? 1 : int'(step_width);
        dir = 32'(s.direction);
        case (s.op)
            OP_ADD:
            begin
                // missing, calm or off-circle samples leave the store alone
                if (!(s.missing || s.speed == '0 || dir > 32'(FULL_CIRCLE)))
                begin
                    // exactly 360.0 degrees folds back onto north
                    if (dir == 32'(FULL_CIRCLE))
                        dir = 0;
                    sec = (dir * SECTORS) / 32'(FULL_CIRCLE);
                    // class k covers (k*step, (k+1)*step]
                    cls = (int'(s.speed) - 1) / eff_step;
                    if (cls > SPEED_CLASSES - 1)
                        cls = SPEED_CLASSES - 1;
                    idx = ADDR_W'(sec * SPEED_CLASSES + cls);
                    // saturate at the counter ceiling
                    if (rose_bins[idx] != COUNT_MAX)
                        rose_bins[idx] = rose_bins[idx] + 1'b1;
                    r.count       = rose_bins[idx];
                    r.counted     = 1'b1;
                    r.sector      = SECTOR_W'(sec);
                    r.speed_class = CLASS_W'(cls);
                end
            end
            OP_READ:
            begin
                // the address is echoed even when it lies outside the store
                if (32'(s.read_sector) < SECTORS && 32'(s.read_class) < SPEED_CLASSES)
                begin
                    idx     = ADDR_W'(32'(s.read_sector) * SPEED_CLASSES
                                      + 32'(s.read_class));
                    r.count = rose_bins[idx];
                end
                r.sector      = s.read_sector;
                r.speed_class = s.read_class;
            end
            OP_CLEAR:
            begin
                foreach (rose_bins[i])
                    rose_bins[i] = '0;
            end
            default:
            begin
                // unused operation: nothing moves, result stays all zero
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_sample(wind_sample_t s);
        pending_samples.insert(pending_samples.size(), s);
        queued_total++;
    endtask

    task automatic queue_fields(logic [OP_W-1:0] op, int unsigned spd, int unsigned dir,
                                bit miss, int unsigned rsec, int unsigned rcls);
        wind_sample_t s;
        s.op          = op;
        s.speed       = SPEED_W'(spd);
        s.direction   = DIR_W'(dir);
        s.missing     = miss;
        s.read_sector = SECTOR_W'(rsec);
        s.read_class  = CLASS_W'(rcls);
        queue_sample(s);
    endtask

    // mostly well-formed adds near class and sector edges, with reads mixed
    // in so counts get checked, plus rare clears, rejects and unused codes
    function automatic wind_sample_t random_sample(logic [STEP_W-1:0] step);
        wind_sample_t s;
        int unsigned pick;
        int unsigned k;
        int unsigned eff_step;
        int unsigned spd;
        eff_step      = (step == '0) ? 1 : int'(step);
        s.op          = OP_ADD;
        s.speed       = SPEED_W'($urandom);
        s.direction   = DIR_W'($urandom);
        s.missing     = 1'b0;
        s.read_sector = SECTOR_W'($urandom);
        s.read_class  = CLASS_W'($urandom_range(0, SPEED_CLASSES - 1));
        pick = $urandom_range(0, 99);
        if (pick < 2)
            s.op = OP_CLEAR;
        else if (pick < 4)
            s.op = OP_UNUSED;
        else if (pick < 26)
        begin
            s.op = OP_READ;
            // now and then address a class that does not exist
            if ($urandom_range(0, 9) == 0)
                s.read_class = CLASS_W'($urandom_range(SPEED_CLASSES, 7));
        end
        else
        begin
            // speed: anywhere, right at a class boundary, or within the lowest three classes
            case ($urandom_range(0, 3))
                0:       spd = $urandom_range(0, 4095);
                1, 2:
                begin
                    k   = $urandom_range(0, SPEED_CLASSES);
                    spd = k * eff_step + $urandom_range(0, 1);
                end
                default: spd = $urandom_range(1, 3 * eff_step);
            endcase
            if (spd > 4095)
                spd = 4095;
            if (spd == 0)
                spd = 1;
            s.speed = SPEED_W'(spd);
            // direction: in range, on a sector edge, at the wrap, or anywhere in the field
            case ($urandom_range(0, 5))
                0, 1:    s.direction = DIR_W'($urandom_range(0, FULL_CIRCLE));
                2, 3:    s.direction = DIR_W'($urandom_range(1, SECTORS) * (3600 / SECTORS)
                                              - $urandom_range(0, 1));
                4:       s.direction = FULL_CIRCLE;
                default: s.direction = DIR_W'($urandom_range(0, 4095));
            endcase
            // a few rejects of each kind
            if ($urandom_range(0, 19) == 0)
                s.missing = 1'b1;
            if ($urandom_range(0, 24) == 0)
                s.speed = '0;
            if ($urandom_range(0, 24) == 0)
                s.direction = DIR_W'($urandom_range(FULL_CIRCLE + 1, 4095));
        end
        return s;
    endfunction

    // block is idle once every queued transfer is taken and answered
    task automatic wait_drained();
        while (accepted_total != queued_total || awaited_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // register write, only ever issued while the block is idle
    task automatic write_step(logic [STEP_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we     = 1'b0;
        step_width = value;
    endtask

    task automatic run_random_phase(int unsigned n);
        repeat (n) queue_sample(random_sample(step_width));
        wait_drained();
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // sender: offers the next pending sample at the falling edge; a held
    // transfer stays put until it is taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            samples_ch.valid <= 1'b0;
        else if (!samples_ch.valid || in_fire)
        begin
            if (pending_samples.size() != 0 &&
                (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                next_sample = pending_samples.pop_front();
                samples_ch.operation   <= next_sample.op;
                samples_ch.speed       <= next_sample.speed;
                samples_ch.direction   <= next_sample.direction;
                samples_ch.missing     <= next_sample.missing;
                samples_ch.read_sector <= next_sample.read_sector;
                samples_ch.read_class  <= next_sample.read_class;
                samples_ch.valid       <= 1'b1;
            end
            else
                samples_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random ready, plus a long hold-off counted here on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            results_ch.ready <= 1'b0;
        else if (hold_served != hold_requests)
        begin
            hold_served      = hold_requests;
            hold_left        = HOLD_CYCLES;
            results_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            results_ch.ready <= 1'b0;
        end
        else
            results_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // monitor: predicts on every sample transfer and checks every result
    // transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bin_result_t  want;
        wind_sample_t taken;
        in_fire <= rst_n && samples_ch.valid && samples_ch.ready;
        if (rst_n && samples_ch.valid && samples_ch.ready)
        begin
            taken.op          = samples_ch.operation;
            taken.speed       = samples_ch.speed;
            taken.direction   = samples_ch.direction;
            taken.missing     = samples_ch.missing;
            taken.read_sector = samples_ch.read_sector;
            taken.read_class  = samples_ch.read_class;
            awaited_results.insert(awaited_results.size(), tally_sample(taken));
            accepted_total++;
        end
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result with nothing awaited, count",
                                32'(results_ch.count), 32'd0);
            else
            begin
                want = awaited_results.pop_front();
                if (results_ch.count !== want.count)
                    report_mismatch("count", 32'(results_ch.count), 32'(want.count));
                if (results_ch.counted !== want.counted)
                    report_mismatch("counted", 32'(results_ch.counted), 32'(want.counted));
                if (results_ch.sector !== want.sector)
                    report_mismatch("sector", 32'(results_ch.sector), 32'(want.sector));
                if (results_ch.speed_class !== want.speed_class)
                    report_mismatch("speed_class", 32'(results_ch.speed_class),
                                    32'(want.speed_class));
            end
        end
    end

    // watchdog on the whole run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // every input known from time zero
        samples_ch.valid       = 1'b0;
        samples_ch.operation   = OP_ADD;
        samples_ch.speed       = '0;
        samples_ch.direction   = '0;
        samples_ch.missing     = 1'b0;
        samples_ch.read_sector = '0;
        samples_ch.read_class  = '0;
        results_ch.ready       = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = STEP_RESET;
        rst_n                  = 1'b0;
        no_idle                = 1'b0;
        in_fire                = 1'b0;
        step_width             = STEP_RESET;
        queued_total           = 0;
        accepted_total         = 0;
        mismatch_count         = 0;
        hold_requests          = 0;
        hold_served            = 0;
        hold_left              = 0;
        foreach (rose_bins[i])
            rose_bins[i] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at the reset step of 80
        queue_fields(OP_ADD,   1,    0,    0, 0, 0);     // slowest, due north
        queue_fields(OP_ADD,   4095, 3599, 0, 0, 0);     // fastest, last sector
        queue_fields(OP_ADD,   80,   3600, 0, 0, 0);     // 360.0 wraps to north
        queue_fields(OP_ADD,   81,   225,  0, 0, 0);     // first speed of class 1, sector edge
        queue_fields(OP_ADD,   400,  224,  0, 0, 0);     // top of class 4, just under edge
        queue_fields(OP_ADD,   401,  1800, 0, 0, 0);     // first speed of the top class
        queue_fields(OP_ADD,   0,    100,  0, 0, 0);     // calm: rejected
        queue_fields(OP_ADD,   100,  100,  1, 0, 0);     // missing: rejected
        queue_fields(OP_ADD,   100,  3601, 0, 0, 0);     // just off the circle
        queue_fields(OP_ADD,   4095, 4095, 1, 15, 7);    // all ones, rejected
        queue_fields(OP_READ,  0,    0,    0, 0, 0);
        queue_fields(OP_READ,  0,    0,    0, 15, 5);
        queue_fields(OP_READ,  0,    0,    0, 1, 1);
        queue_fields(OP_READ,  0,    0,    0, 0, 4);
        queue_fields(OP_READ,  0,    0,    0, 8, 5);
        queue_fields(OP_READ,  0,    0,    0, 0, 6);     // class out of range
        queue_fields(OP_READ,  4095, 4095, 1, 15, 7);    // out of range, all ones
        queue_fields(OP_UNUSED, 4095, 4095, 1, 15, 7);   // unused code ignored
        queue_fields(OP_UNUSED, 0,   0,    0, 0, 0);
        queue_fields(OP_CLEAR, 4095, 4095, 1, 15, 7);
        queue_fields(OP_READ,  0,    0,    0, 0, 0);     // zero after clear
        queue_fields(OP_ADD,   160,  1800, 0, 3, 2);
        queue_fields(OP_ADD,   160,  1800, 0, 3, 2);
        queue_fields(OP_READ,  0,    0,    0, 8, 1);
        wait_drained();

        run_random_phase(PHASE_ITEMS);

        // narrowest step; the receiver holds off while the sender keeps going
        write_step(STEP_W'(1));
        hold_requests++;
        run_random_phase(PHASE_ITEMS);

        // widest step, both sides at full rate
        write_step(STEP_W'(1023));
        no_idle = 1'b1;
        run_random_phase(PHASE_ITEMS);
        no_idle = 1'b0;

        // zero step behaves as one
        write_step(STEP_W'(0));
        run_random_phase(PHASE_ITEMS);

        write_step(STEP_W'($urandom_range(2, 1022)));
        run_random_phase(PHASE_ITEMS);

        write_step(STEP_RESET);
        run_random_phase(PHASE_ITEMS);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
